/* hw/rtl/svlt_pkg.sv */
// Shared types, codes and helpers of the sample voice loop tracker.
package svlt_pkg;

   localparam int VOICES_DEFAULT        = 4;
   localparam int POSITION_BITS_DEFAULT = 24;
   localparam int POS_MAX_W             = 32;
   localparam int CSR_INDEX_W           = 1;
   localparam int CSR_DATA_W            = 32;

   // Input actions.
   localparam logic [1:0] ACT_PLAY  = 2'd0;
   localparam logic [1:0] ACT_STOP  = 2'd1;
   localparam logic [1:0] ACT_TICK  = 2'd2;
   localparam logic [1:0] ACT_TIMER = 2'd3;

   // Result kinds.
   localparam logic [2:0] KIND_STOP    = 3'd0;
   localparam logic [2:0] KIND_PROGRAM = 3'd1;
   localparam logic [2:0] KIND_REPEAT  = 3'd2;
   localparam logic [2:0] KIND_ENABLE  = 3'd3;
   localparam logic [2:0] KIND_ARM     = 3'd4;

   // Configuration register indexes.
   localparam logic [CSR_INDEX_W-1:0] CSR_ZERO_SAMPLE = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_CLOCKS      = 1'd1;

   localparam logic [19:0] CLOCKS_PER_FRAME_RESET = 20'd70937;

   // Play state of one voice as kept in the voice memory.
   typedef struct packed {
      logic [POS_MAX_W-1:0] position;
      logic [31:0]          base_address;
      logic [23:0]          loop_start;
      logic [23:0]          loop_end;
      logic [23:0]          loop_end_later;
      logic [1:0]           mode;
      logic [31:0]          repeat_pointer;
      logic [15:0]          repeat_length;
      logic [15:0]          period;
   } svlt_voice_type;

   localparam svlt_voice_type VOICE_RESET = '{
      position:       '0,
      base_address:   '0,
      loop_start:     '0,
      loop_end:       '0,
      loop_end_later: '0,
      mode:           '0,
      repeat_pointer: '0,
      repeat_length:  16'd1,
      period:         16'd1
   };

   // Status of the shared divider.
   typedef struct packed {
      logic busy;
      logic done;
   } svlt_div_status_type;

   // Half the byte distance, zero when the end is not above the start.
   function automatic logic [15:0] words_between(input logic [31:0] from_pos,
                                                 input logic [31:0] to_pos);
      logic [31:0] diff;
      diff = to_pos - from_pos;
      if (to_pos <= from_pos) begin
         return 16'd0;
      end
      return diff[16:1];
   endfunction

endpackage

/* hw/rtl/svlt_ram.sv */
// Generic single-port-write, registered-read RAM.
module svlt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  logic                                  clock,
   input  logic                                  wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                      wr_data,
   input  logic                                  rd_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                      rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* hw/rtl/svlt_divider.sv */
// Restoring divider, one quotient bit per cycle.
module svlt_divider #(
   parameter int WIDTH = 24
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [WIDTH-1:0]             dividend,
   input  logic [WIDTH-1:0]             divisor,
   output svlt_pkg::svlt_div_status_type status,
   output logic [WIDTH-1:0]             quotient,
   output logic [WIDTH-1:0]             remainder
);

   localparam int CNT_W = $clog2(WIDTH + 1);

   logic [WIDTH-1:0] rem_ff, rem_in;
   logic [WIDTH-1:0] quo_ff, quo_in;
   logic [WIDTH-1:0] den_ff, den_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [WIDTH:0]   trial;

   always_comb begin
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial   = {rem_ff, quo_ff[WIDTH-1]};
      if (start) begin
         rem_in  = '0;
         quo_in  = dividend;
         den_in  = divisor;
         cnt_in  = CNT_W'(WIDTH);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (trial >= {1'b0, den_ff}) begin
            rem_in = WIDTH'(trial - {1'b0, den_ff});
            quo_in = {quo_ff[WIDTH-2:0], 1'b1};
         end else begin
            rem_in = trial[WIDTH-1:0];
            quo_in = {quo_ff[WIDTH-2:0], 1'b0};
         end
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      den_ff <= den_in;
   end

   assign status.busy = busy_ff;
   assign status.done = done_ff;
   assign quotient    = quo_ff;
   assign remainder   = rem_ff;

endmodule

/* hw/rtl/sample_voice_loop_tracker.sv */
// Top level of the sample voice loop tracker: sequencer, voice memory and divider.

// The block keeps the play state of VOICES sample voices in a small memory with
// a registered read, and walks each input word through a sequencer that reads a
// voice record, modifies it and writes it back. A stop word loads the record, emits
// a stop result and writes back the stopped state. A play word loads the record,
// emits a stop result and, unless it has run past the end of a non-looping sample,
// programs the voice; when its position must be wrapped into the loop, the shared
// restoring divider takes the remainder first. A frame tick visits every voice in
// turn with one divider pass for the position advance and a second pass for a
// one-shot voice that turns into a loop, then arms the timer if a voice is pending.
// A timer word reports the enable mask of pending voices, or else the repeat
// settings of up to four voices. A result that waits on rsp_stall holds the
// sequencer. Result words are held in an output register, so the next input word
// is taken while the last result still waits on rsp_stall. Voice records that were
// never written read as their reset values through one valid flop per voice, so no
// clearing pass is needed after reset.
module sample_voice_loop_tracker #(
   parameter int VOICES        = svlt_pkg::VOICES_DEFAULT,
   parameter int POSITION_BITS = svlt_pkg::POSITION_BITS_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [1:0]                        req_action,
   input  logic [1:0]                        req_voice,
   input  logic [31:0]                       req_sample_address,
   input  logic [23:0]                       req_given_position,
   input  logic                              req_use_given_position,
   input  logic [23:0]                       req_loop_begin,
   input  logic [23:0]                       req_loop_finish,
   input  logic [23:0]                       req_loop_finish_later,
   input  logic                              req_looping,
   input  logic                              req_one_shot_then_loop,
   input  logic [25:0]                       req_raw_period,
   input  logic [28:0]                       req_raw_volume_left_right,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [2:0]                        rsp_kind,
   output logic [1:0]                        rsp_out_voice,
   output logic [31:0]                       rsp_address,
   output logic [15:0]                       rsp_length_words,
   output logic [15:0]                       rsp_period,
   output logic [6:0]                        rsp_volume,
   output logic [3:0]                        rsp_enable_mask,
   output logic                              rsp_last,
   input  logic                              csr_write,
   input  logic [svlt_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [svlt_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   // Positions are kept wide enough for both the position mask and the 24-bit
   // loop offsets, since an empty loop stores its start unmasked.
   localparam int DW   = (POSITION_BITS > 24) ? POSITION_BITS : 24;
   localparam int VI_W = (VOICES > 1) ? $clog2(VOICES) : 1;
   localparam int NREP = (VOICES < 4) ? VOICES : 4;
   localparam logic [DW-1:0] POS_MASK = DW'((33'd1 << POSITION_BITS) - 33'd1);

   localparam logic [3:0] ST_IDLE   = 4'd0;
   localparam logic [3:0] ST_LOAD   = 4'd1;
   localparam logic [3:0] ST_P_STOP = 4'd2;
   localparam logic [3:0] ST_P_MOD  = 4'd3;
   localparam logic [3:0] ST_P_PROG = 4'd4;
   localparam logic [3:0] ST_S_STOP = 4'd5;
   localparam logic [3:0] ST_T_READ = 4'd6;
   localparam logic [3:0] ST_T_CONV = 4'd7;
   localparam logic [3:0] ST_T_MOD  = 4'd8;
   localparam logic [3:0] ST_T_DIV  = 4'd9;
   localparam logic [3:0] ST_T_ADV  = 4'd10;
   localparam logic [3:0] ST_T_ARM  = 4'd11;
   localparam logic [3:0] ST_R_READ = 4'd12;
   localparam logic [3:0] ST_R_EMIT = 4'd13;
   localparam logic [3:0] ST_M_MASK = 4'd14;

   // Configuration registers.
   logic [31:0] zero_sample_ff;
   logic [19:0] clocks_ff;

   // Sequencer state.
   logic [3:0]        state_ff, state_in;
   logic [VI_W-1:0]   idx_ff, idx_in;
   logic [VOICES-1:0] pending_ff, pending_in;
   logic [VOICES-1:0] valid_ff;
   logic [DW-1:0]     pos_ff, pos_in;
   svlt_pkg::svlt_voice_type rec_ff, rec_in;

   // Latched input word.
   logic [1:0]  item_action_ff;
   logic [1:0]  item_voice_ff;
   logic [31:0] item_sample_ff;
   logic [23:0] item_given_ff;
   logic        item_use_given_ff;
   logic [23:0] item_ls_ff;
   logic [23:0] item_le_ff;
   logic [23:0] item_lel_ff;
   logic        item_loops_ff;
   logic        item_oneshot_ff;
   logic [25:0] item_rper_ff;
   logic [28:0] item_rvol_ff;

   // Output register.
   logic        rsp_valid_ff, rsp_valid_in;
   logic [2:0]  rsp_kind_ff;
   logic [1:0]  rsp_voice_ff;
   logic [31:0] rsp_address_ff;
   logic [15:0] rsp_length_ff;
   logic [15:0] rsp_period_ff;
   logic [6:0]  rsp_volume_ff;
   logic [3:0]  rsp_mask_ff;
   logic        rsp_last_ff;

   // Result being produced this cycle.
   logic        emit;
   logic        emit_ok;
   logic [2:0]  e_kind;
   logic [1:0]  e_voice;
   logic [31:0] e_addr;
   logic [15:0] e_len;
   logic [15:0] e_per;
   logic [6:0]  e_vol;
   logic [3:0]  e_mask;
   logic        e_last;

   // Memory and divider hookup.
   logic                     rd_en;
   logic [VI_W-1:0]          rd_addr;
   svlt_pkg::svlt_voice_type rd_rec;
   logic                     wr_en;
   logic [VI_W-1:0]          wr_addr;
   svlt_pkg::svlt_voice_type wr_rec;
   logic                     div_start;
   logic [DW-1:0]            div_a;
   logic [DW-1:0]            div_b;
   svlt_pkg::svlt_div_status_type div_status;
   logic [DW-1:0]            div_quo;
   logic [DW-1:0]            div_rem;

   // Work signals.
   logic            accept;
   logic            req_in_range;
   logic [VI_W-1:0] item_vidx;
   logic [DW-1:0]   play_pos;
   logic            past_end;
   logic            wrap_empty;
   logic [8:0]      vol_sum;
   logic [6:0]      vol_raw;
   logic [DW-1:0]   cur_pos;
   logic [DW:0]     adv_sum;
   logic [DW-1:0]   adv_pos;
   logic            last_voice;
   logic            last_report;

   svlt_ram #(
      .WIDTH($bits(svlt_pkg::svlt_voice_type)),
      .DEPTH(VOICES)
   ) u_voice_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_rec),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_rec)
   );

   svlt_divider #(
      .WIDTH(DW)
   ) u_divider (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (div_a),
      .divisor   (div_b),
      .status    (div_status),
      .quotient  (div_quo),
      .remainder (div_rem)
   );

   assign req_stall    = (state_ff != ST_IDLE);
   assign accept       = req_valid && !req_stall;
   assign req_in_range = 32'(req_voice) < 32'(VOICES);
   assign item_vidx    = VI_W'(item_voice_ff);
   assign emit_ok      = !rsp_valid_ff || !rsp_stall;

   // Play position: override or tracked, masked, then checked against the end.
   assign play_pos   = (item_use_given_ff ? DW'(item_given_ff) : rec_ff.position[DW-1:0])
                       & POS_MASK;
   assign past_end   = play_pos >= DW'(item_le_ff);
   assign wrap_empty = (item_le_ff <= item_ls_ff) || (play_pos < DW'(item_ls_ff));

   // Volume never exceeds 32 from a 29-bit input, the clamp keeps the rule.
   assign vol_sum = 9'(item_rvol_ff[28:21]) + 9'd6;
   assign vol_raw = 7'(vol_sum[8:3]);

   assign cur_pos     = rec_ff.position[DW-1:0];
   assign adv_sum     = {1'b0, cur_pos} + {1'b0, div_quo};
   assign adv_pos     = (adv_sum > {1'b0, POS_MASK}) ? POS_MASK : adv_sum[DW-1:0];
   assign last_voice  = idx_ff == VI_W'(VOICES - 1);
   assign last_report = idx_ff == VI_W'(NREP - 1);

   // Address of the record now in the read register: the voice of a play or
   // stop word, otherwise the voice being visited.
   function automatic logic [VI_W-1:0] rd_addr_q();
      logic [VI_W-1:0] a;
      a = ((item_action_ff == svlt_pkg::ACT_PLAY) || (item_action_ff == svlt_pkg::ACT_STOP))
          ? item_vidx : idx_ff;
      return a;
   endfunction

   always_comb begin
      state_in   = state_ff;
      idx_in     = idx_ff;
      pending_in = pending_ff;
      pos_in     = pos_ff;
      rec_in     = rec_ff;
      emit       = 1'b0;
      e_kind     = svlt_pkg::KIND_STOP;
      e_voice    = 2'd0;
      e_addr     = 32'd0;
      e_len      = 16'd0;
      e_per      = 16'd0;
      e_vol      = 7'd0;
      e_mask     = 4'd0;
      e_last     = 1'b0;
      rd_en      = 1'b0;
      rd_addr    = idx_ff;
      wr_en      = 1'b0;
      wr_addr    = item_vidx;
      wr_rec     = rec_ff;
      div_start  = 1'b0;
      div_a      = '0;
      div_b      = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               rd_en   = 1'b1;
               rd_addr = VI_W'(req_voice);
               idx_in  = '0;
               unique case (req_action)
                  svlt_pkg::ACT_PLAY,
                  svlt_pkg::ACT_STOP: begin
                     state_in = req_in_range ? ST_LOAD : ST_IDLE;
                  end
                  svlt_pkg::ACT_TICK: begin
                     state_in = ST_T_READ;
                  end
                  svlt_pkg::ACT_TIMER: begin
                     state_in = (pending_ff != '0) ? ST_M_MASK : ST_R_READ;
                  end
                  default: begin
                     state_in = ST_IDLE;
                  end
               endcase
            end
         end

         ST_LOAD: begin
            rec_in = valid_ff[rd_addr_q()] ? rd_rec : svlt_pkg::VOICE_RESET;
            unique case (item_action_ff)
               svlt_pkg::ACT_PLAY:  state_in = ST_P_STOP;
               svlt_pkg::ACT_STOP:  state_in = ST_S_STOP;
               svlt_pkg::ACT_TICK:  state_in = ST_T_CONV;
               svlt_pkg::ACT_TIMER: state_in = ST_R_EMIT;
               default:             state_in = ST_IDLE;
            endcase
         end

         ST_P_STOP: begin
            if (emit_ok) begin
               emit    = 1'b1;
               e_kind  = svlt_pkg::KIND_STOP;
               e_voice = item_voice_ff;
               e_last  = past_end && !item_loops_ff;
               if (past_end && !item_loops_ff) begin
                  // Retire: loop data still stored, play state cleared.
                  wr_en                 = 1'b1;
                  wr_rec                = svlt_pkg::VOICE_RESET;
                  wr_rec.base_address   = item_sample_ff;
                  wr_rec.loop_start     = item_ls_ff;
                  wr_rec.loop_end       = item_le_ff;
                  wr_rec.loop_end_later = item_lel_ff;
                  wr_rec.mode           = {item_oneshot_ff, item_loops_ff};
                  state_in              = ST_IDLE;
               end else if (past_end && !wrap_empty) begin
                  div_start = 1'b1;
                  div_a     = play_pos - DW'(item_ls_ff);
                  div_b     = DW'(item_le_ff) - DW'(item_ls_ff);
                  state_in  = ST_P_MOD;
               end else begin
                  pos_in   = past_end ? DW'(item_ls_ff) : play_pos;
                  state_in = ST_P_PROG;
               end
            end
         end

         ST_P_MOD: begin
            if (div_status.done) begin
               pos_in   = (div_rem + DW'(item_ls_ff)) & POS_MASK;
               state_in = ST_P_PROG;
            end
         end

         ST_P_PROG: begin
            if (emit_ok) begin
               emit    = 1'b1;
               e_kind  = svlt_pkg::KIND_PROGRAM;
               e_voice = item_voice_ff;
               e_addr  = item_sample_ff + 32'(pos_ff);
               e_len   = svlt_pkg::words_between(32'(pos_ff), 32'(item_le_ff));
               e_per   = item_rper_ff[25:10];
               e_vol   = (vol_raw > 7'd64) ? 7'd64 : vol_raw;
               e_last  = 1'b1;
               wr_en                 = 1'b1;
               wr_rec.position       = svlt_pkg::POS_MAX_W'(pos_ff);
               wr_rec.base_address   = item_sample_ff;
               wr_rec.loop_start     = item_ls_ff;
               wr_rec.loop_end       = item_le_ff;
               wr_rec.loop_end_later = item_lel_ff;
               wr_rec.mode           = {item_oneshot_ff, item_loops_ff};
               wr_rec.period         = item_rper_ff[25:10];
               if (item_loops_ff) begin
                  wr_rec.repeat_pointer = item_sample_ff + 32'(item_ls_ff);
                  wr_rec.repeat_length  = svlt_pkg::words_between(32'(item_ls_ff),
                                                                  32'(item_le_ff));
               end else begin
                  wr_rec.repeat_pointer = zero_sample_ff;
                  wr_rec.repeat_length  = 16'd1;
               end
               pending_in = pending_ff | (VOICES'(1) << item_vidx);
               state_in   = ST_IDLE;
            end
         end

         ST_S_STOP: begin
            if (emit_ok) begin
               emit                  = 1'b1;
               e_kind                = svlt_pkg::KIND_STOP;
               e_voice               = item_voice_ff;
               e_last                = 1'b1;
               wr_en                 = 1'b1;
               wr_rec.position       = '0;
               wr_rec.repeat_pointer = '0;
               wr_rec.repeat_length  = 16'd1;
               wr_rec.period         = 16'd1;
               state_in              = ST_IDLE;
            end
         end

         ST_T_READ: begin
            rd_en    = 1'b1;
            rd_addr  = idx_ff;
            state_in = ST_LOAD;
         end

         ST_T_CONV: begin
            // A finished one-shot-then-loop voice switches to its later loop end.
            if (!rec_ff.mode[0] && rec_ff.mode[1] && (cur_pos >= DW'(rec_ff.loop_end))) begin
               rec_in.mode           = 2'b01;
               rec_in.loop_end       = rec_ff.loop_end_later;
               rec_in.repeat_pointer = rec_ff.base_address;
               rec_in.repeat_length  = svlt_pkg::words_between(32'(rec_ff.loop_start),
                                                               32'(rec_ff.loop_end_later));
               pending_in            = pending_ff | (VOICES'(1) << idx_ff);
               if ((rec_ff.loop_end_later <= rec_ff.loop_start) ||
                   (cur_pos < DW'(rec_ff.loop_start))) begin
                  rec_in.position = svlt_pkg::POS_MAX_W'(rec_ff.loop_start);
                  state_in        = ST_T_DIV;
               end else begin
                  div_start = 1'b1;
                  div_a     = cur_pos - DW'(rec_ff.loop_start);
                  div_b     = DW'(rec_ff.loop_end_later) - DW'(rec_ff.loop_start);
                  state_in  = ST_T_MOD;
               end
            end else begin
               state_in = ST_T_DIV;
            end
         end

         ST_T_MOD: begin
            if (div_status.done) begin
               rec_in.position = svlt_pkg::POS_MAX_W'((div_rem + DW'(rec_ff.loop_start))
                                                      & POS_MASK);
               state_in        = ST_T_DIV;
            end
         end

         ST_T_DIV: begin
            div_start = 1'b1;
            div_a     = DW'(clocks_ff);
            div_b     = (rec_ff.period == 16'd0) ? DW'(1) : DW'(rec_ff.period);
            state_in  = ST_T_ADV;
         end

         ST_T_ADV: begin
            if (div_status.done) begin
               wr_en           = 1'b1;
               wr_addr         = idx_ff;
               wr_rec.position = svlt_pkg::POS_MAX_W'(adv_pos);
               if (last_voice) begin
                  state_in = ST_T_ARM;
               end else begin
                  idx_in   = idx_ff + VI_W'(1);
                  state_in = ST_T_READ;
               end
            end
         end

         ST_T_ARM: begin
            if (pending_ff == '0) begin
               state_in = ST_IDLE;
            end else if (emit_ok) begin
               emit     = 1'b1;
               e_kind   = svlt_pkg::KIND_ARM;
               e_last   = 1'b1;
               state_in = ST_IDLE;
            end
         end

         ST_R_READ: begin
            rd_en    = 1'b1;
            rd_addr  = idx_ff;
            state_in = ST_LOAD;
         end

         ST_R_EMIT: begin
            if (emit_ok) begin
               emit    = 1'b1;
               e_kind  = svlt_pkg::KIND_REPEAT;
               e_voice = 2'(idx_ff);
               e_addr  = rec_ff.repeat_pointer;
               e_len   = rec_ff.repeat_length;
               e_last  = last_report;
               if (last_report) begin
                  state_in = ST_IDLE;
               end else begin
                  idx_in   = idx_ff + VI_W'(1);
                  state_in = ST_R_READ;
               end
            end
         end

         ST_M_MASK: begin
            if (emit_ok) begin
               emit       = 1'b1;
               e_kind     = svlt_pkg::KIND_ENABLE;
               e_mask     = 4'(pending_ff);
               e_last     = 1'b1;
               pending_in = '0;
               state_in   = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (emit) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         idx_ff         <= '0;
         pending_ff     <= '0;
         valid_ff       <= '0;
         rsp_valid_ff   <= 1'b0;
         zero_sample_ff <= 32'd0;
         clocks_ff      <= svlt_pkg::CLOCKS_PER_FRAME_RESET;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         pending_ff   <= pending_in;
         rsp_valid_ff <= rsp_valid_in;
         if (wr_en) begin
            valid_ff[wr_addr] <= 1'b1;
         end
         if (csr_write) begin
            unique case (csr_index)
               svlt_pkg::CSR_ZERO_SAMPLE: zero_sample_ff <= csr_wdata;
               svlt_pkg::CSR_CLOCKS:      clocks_ff      <= csr_wdata[19:0];
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      pos_ff <= pos_in;
      rec_ff <= rec_in;
      if (accept) begin
         item_action_ff    <= req_action;
         item_voice_ff     <= req_voice;
         item_sample_ff    <= req_sample_address;
         item_given_ff     <= req_given_position;
         item_use_given_ff <= req_use_given_position;
         item_ls_ff        <= req_loop_begin;
         item_le_ff        <= req_loop_finish;
         item_lel_ff       <= req_loop_finish_later;
         item_loops_ff     <= req_looping;
         item_oneshot_ff   <= req_one_shot_then_loop;
         item_rper_ff      <= req_raw_period;
         item_rvol_ff      <= req_raw_volume_left_right;
      end
      if (emit) begin
         rsp_kind_ff    <= e_kind;
         rsp_voice_ff   <= e_voice;
         rsp_address_ff <= e_addr;
         rsp_length_ff  <= e_len;
         rsp_period_ff  <= e_per;
         rsp_volume_ff  <= e_vol;
         rsp_mask_ff    <= e_mask;
         rsp_last_ff    <= e_last;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_kind         = rsp_kind_ff;
   assign rsp_out_voice    = rsp_voice_ff;
   assign rsp_address      = rsp_address_ff;
   assign rsp_length_words = rsp_length_ff;
   assign rsp_period       = rsp_period_ff;
   assign rsp_volume       = rsp_volume_ff;
   assign rsp_enable_mask  = rsp_mask_ff;
   assign rsp_last         = rsp_last_ff;

`ifndef SYNTHESIS
   // The divider is never restarted while a division is in flight.
   assert property (@(posedge clock) disable iff (reset)
      div_start |-> !div_status.busy)
      else $error("divider started while busy");

   // A waiting result that is not the last of its word means work goes on.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_last_ff) |-> (state_ff != ST_IDLE))
      else $error("sequencer idle before the last result");

   // The voice memory is written only while a word is being worked on.
   assert property (@(posedge clock) disable iff (reset)
      wr_en |-> (state_ff != ST_IDLE) && !accept)
      else $error("voice memory written while idle");

   // A word is never taken while a result is being produced.
   assert property (@(posedge clock) disable iff (reset)
      accept |-> !emit)
      else $error("input taken during result production");
`endif

endmodule
